[rtl/core/blte_pkg.sv]
`timescale 1ns / 1ps

package blte_pkg;

    localparam int CMD_W  = 3;
    localparam int VAL_W  = 32;
    localparam int SUM_W  = 36;
    localparam int CNT_W  = 5;
    localparam int STAT_W = 2;

    // command codes
    localparam logic [CMD_W-1:0] CMD_APPEND    = 3'd0;
    localparam logic [CMD_W-1:0] CMD_DEL_FIRST = 3'd1;
    localparam logic [CMD_W-1:0] CMD_DEL_ALL   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_SEARCH    = 3'd3;
    localparam logic [CMD_W-1:0] CMD_COUNT     = 3'd4;
    localparam logic [CMD_W-1:0] CMD_CLEAR     = 3'd5;
    localparam logic [CMD_W-1:0] CMD_STATS     = 3'd6;
    localparam logic [CMD_W-1:0] CMD_RSVD      = 3'd7;

    // status codes
    localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL      = 2'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY     = 2'd2;
    localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd3;

    // chain control: shift goes to every cell, load only to the indexed cell
    typedef struct packed {
        logic shift;
        logic load;
    } t_chain_ctl;

endpackage

[rtl/core/blte_cell.sv]
`timescale 1ns / 1ps

module blte_cell (
    input  logic                       i_clk,
    input  logic                       i_shift,
    input  logic                       i_load,
    input  logic [blte_pkg::VAL_W-1:0] i_load_data,
    input  logic [blte_pkg::VAL_W-1:0] i_next,
    output logic [blte_pkg::VAL_W-1:0] o_data
);
    import blte_pkg::*;

    logic [VAL_W-1:0] r_data;

    // load wins over the neighbor; otherwise hold
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_data <= i_load_data;
        end else if (i_shift) begin
            r_data <= i_next;
        end
    end

    assign o_data = r_data;

endmodule

[rtl/core/blte_chain.sv]
`timescale 1ns / 1ps

module blte_chain #(
    parameter int CAPACITY = 16,
    parameter int IW       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
    input  logic                       i_clk,
    input  blte_pkg::t_chain_ctl       i_ctl,
    input  logic [IW-1:0]              i_load_idx,
    input  logic [blte_pkg::VAL_W-1:0] i_load_data,
    output logic [blte_pkg::VAL_W-1:0] o_head
);
    import blte_pkg::*;

    logic [VAL_W-1:0] w_data [CAPACITY];

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [VAL_W-1:0] w_next;

        // last cell has no neighbor; its shifted value is never read
        if (g == CAPACITY - 1) begin : g_tail
            assign w_next = i_load_data;
        end else begin : g_mid
            assign w_next = w_data[g+1];
        end

        blte_cell u_cell (
            .i_clk       (i_clk),
            .i_shift     (i_ctl.shift),
            .i_load      (i_ctl.load && (i_load_idx == IW'(g))),
            .i_load_data (i_load_data),
            .i_next      (w_next),
            .o_data      (w_data[g])
        );
    end

    assign o_head = w_data[0];

endmodule

[rtl/core/bounded_list_table_engine.sv]
`timescale 1ns / 1ps

// Channel   Valid     Stall     Payload
// input     i_valid   o_stall   i_command, i_value
// result    o_valid   i_stall   o_status, o_position, o_match_count, o_fill_count,
//                               o_is_empty, o_is_full, o_total, o_smallest, o_largest
//
// One item at a time: an accept step, then a walk step per filled entry, then a
// done step that loads the result register once it is free. The walk pops cell 0
// of the chain each cycle and pushes it back at the tail of the list unless deleted.
// A new item is taken while the previous result still waits under i_stall; the
// finished item holds in the done state until the result register frees up.
// Reset (i_rst_n, synchronous) empties the list; entry contents are not cleared.

module bounded_list_table_engine #(
    parameter int CAPACITY = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [blte_pkg::CMD_W-1:0]  i_command,
    input  logic [blte_pkg::VAL_W-1:0]  i_value,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [blte_pkg::STAT_W-1:0] o_status,
    output logic [blte_pkg::CNT_W-1:0]  o_position,
    output logic [blte_pkg::CNT_W-1:0]  o_match_count,
    output logic [blte_pkg::CNT_W-1:0]  o_fill_count,
    output logic                        o_is_empty,
    output logic                        o_is_full,
    output logic [blte_pkg::SUM_W-1:0]  o_total,
    output logic [blte_pkg::VAL_W-1:0]  o_smallest,
    output logic [blte_pkg::VAL_W-1:0]  o_largest
);
    import blte_pkg::*;

    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_DONE
    } t_state;

    t_state           r_state;
    logic [CW-1:0]    r_len;        // fill count, live through the walk
    logic [CW-1:0]    r_pops;       // entries still to visit
    logic [CW-1:0]    r_idx;        // original position of the head
    logic [CW-1:0]    r_pos;
    logic [CW-1:0]    r_matches;
    logic             r_found;
    logic             r_any;        // at least one entry kept so far
    logic             r_was_empty;
    logic             r_full_hit;
    logic [CMD_W-1:0] r_cmd;
    logic [VAL_W-1:0] r_value;
    logic [SUM_W-1:0] r_sum;
    logic [VAL_W-1:0] r_lo;
    logic [VAL_W-1:0] r_hi;

    logic              r_out_valid;
    logic [STAT_W-1:0] r_out_status;
    logic [CW-1:0]     r_out_pos;
    logic [CW-1:0]     r_out_matches;
    logic [CW-1:0]     r_out_fill;
    logic              r_out_full;
    logic [SUM_W-1:0]  r_out_sum;
    logic [VAL_W-1:0]  r_out_lo;
    logic [VAL_W-1:0]  r_out_hi;

    logic             w_accept;
    logic             w_is_append;
    logic             w_full;
    logic [CW-1:0]    n_len;
    logic [VAL_W-1:0] w_head;
    logic [SUM_W-1:0] w_head_wide;
    logic             w_match;
    logic             w_first_hit;
    logic             w_discard;
    logic             w_out_free;
    logic [STAT_W-1:0] w_status;
    t_chain_ctl       w_ctl;
    logic [IW-1:0]    w_load_idx;
    logic [VAL_W-1:0] w_load_data;

    assign o_stall     = (r_state != S_IDLE);
    assign w_accept    = i_valid && !o_stall;
    assign w_is_append = (i_command == CMD_APPEND);
    assign w_full      = (r_len >= CAP_C);
    assign w_out_free  = !r_out_valid || !i_stall;

    // fill count once the accept cycle has applied append or clear
    always_comb begin
        n_len = r_len;
        if (w_is_append && !w_full) begin
            n_len = r_len + CW'(1);
        end else if (i_command == CMD_CLEAR) begin
            n_len = '0;
        end
    end

    // head of the list against the operand
    assign w_head_wide = {{(SUM_W - VAL_W){w_head[VAL_W-1]}}, w_head};
    assign w_match     = (w_head == r_value);
    assign w_first_hit = w_match && !r_found;
    assign w_discard   = ((r_cmd == CMD_DEL_FIRST) && w_first_hit) ||
                         ((r_cmd == CMD_DEL_ALL) && w_match);

    // chain control: append writes slot r_len; the walk pushes the head
    // back at the tail of the shortened list unless it is dropped
    always_comb begin
        w_ctl       = '0;
        w_load_idx  = r_len[IW-1:0];
        w_load_data = i_value;
        if (r_state == S_WALK) begin
            w_ctl.shift = 1'b1;
            w_ctl.load  = !w_discard;
            w_load_idx  = IW'(r_len - CW'(1));
            w_load_data = w_head;
        end else if (w_accept && w_is_append && !w_full) begin
            w_ctl.load = 1'b1;
        end
    end

    blte_chain #(
        .CAPACITY (CAPACITY),
        .IW       (IW)
    ) u_chain (
        .i_clk       (i_clk),
        .i_ctl       (w_ctl),
        .i_load_idx  (w_load_idx),
        .i_load_data (w_load_data),
        .o_head      (w_head)
    );

    // result status from what the walk saw
    always_comb begin
        unique case (r_cmd)
            CMD_APPEND: begin
                w_status = r_full_hit ? ST_FULL : ST_OK;
            end
            CMD_DEL_FIRST, CMD_DEL_ALL, CMD_SEARCH, CMD_COUNT: begin
                if (r_was_empty) begin
                    w_status = ST_EMPTY;
                end else if (!r_found) begin
                    w_status = ST_NOT_FOUND;
                end else begin
                    w_status = ST_OK;
                end
            end
            CMD_CLEAR: begin
                w_status = ST_OK;
            end
            default: begin
                // stats, and the reserved code acting as stats
                w_status = r_was_empty ? ST_EMPTY : ST_OK;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_len       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // drop the result once taken; the done state reloads it itself
            if (r_out_valid && !i_stall && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_cmd       <= i_command;
                        r_value     <= i_value;
                        r_was_empty <= (r_len == '0);
                        r_full_hit  <= w_is_append && w_full;
                        r_len       <= n_len;
                        r_pops      <= n_len;
                        r_idx       <= '0;
                        r_pos       <= '0;
                        r_matches   <= '0;
                        r_found     <= 1'b0;
                        r_any       <= 1'b0;
                        r_sum       <= '0;
                        r_lo        <= '0;
                        r_hi        <= '0;
                        r_state     <= (n_len == '0) ? S_DONE : S_WALK;
                    end
                end
                S_WALK: begin
                    if (w_match) begin
                        r_matches <= r_matches + CW'(1);
                    end
                    if (w_first_hit) begin
                        r_found <= 1'b1;
                        r_pos   <= r_idx + CW'(1);
                    end
                    if (w_discard) begin
                        r_len <= r_len - CW'(1);
                    end else begin
                        // fold the kept entry into the statistics
                        r_sum <= r_sum + w_head_wide;
                        r_any <= 1'b1;
                        if (!r_any || ($signed(w_head) < $signed(r_lo))) begin
                            r_lo <= w_head;
                        end
                        if (!r_any || ($signed(w_head) > $signed(r_hi))) begin
                            r_hi <= w_head;
                        end
                    end
                    r_idx  <= r_idx + CW'(1);
                    r_pops <= r_pops - CW'(1);
                    if (r_pops == CW'(1)) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    // hold until the result register is free
                    if (w_out_free) begin
                        r_out_valid   <= 1'b1;
                        r_out_status  <= w_status;
                        r_out_pos     <= ((r_cmd == CMD_SEARCH) || (r_cmd == CMD_DEL_FIRST))
                                         ? r_pos : '0;
                        r_out_matches <= ((r_cmd == CMD_COUNT) || (r_cmd == CMD_DEL_ALL))
                                         ? r_matches : '0;
                        r_out_fill    <= r_len;
                        r_out_full    <= (r_len == CAP_C);
                        r_out_sum     <= r_sum;
                        r_out_lo      <= r_lo;
                        r_out_hi      <= r_hi;
                        r_state       <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_valid       = r_out_valid;
    assign o_status      = r_out_status;
    assign o_position    = CNT_W'(r_out_pos);
    assign o_match_count = CNT_W'(r_out_matches);
    assign o_fill_count  = CNT_W'(r_out_fill);
    assign o_is_empty    = (r_out_fill == '0);
    assign o_is_full     = r_out_full;
    assign o_total       = r_out_sum;
    assign o_smallest    = r_out_lo;
    assign o_largest     = r_out_hi;

endmodule
